>>> design/fcf_pkg.sv
// Shared constants and types for the FIR convolution filter.
package fcf_pkg;

  localparam int MAX_TAPS    = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int TAP_BITS    = $clog2(MAX_TAPS);
  localparam int CNT_BITS    = $clog2(MAX_TAPS + 1);
  localparam int CFG_BITS    = 13;
  localparam int IDX_BITS    = 12;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int ACC_BITS    = PROD_BITS + CNT_BITS;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;

  localparam logic [CFG_BITS-1:0] TAP_COUNT_RESET = 13'd4096;

  localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'((64'sd1 <<< FRAC_BITS) - 64'sd1);
  localparam logic signed [ACC_BITS-1:0] SAT_LO = ACC_BITS'(-(64'sd1 <<< FRAC_BITS));
  localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(64'sd1 <<< (FRAC_BITS - 1));

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND
  } state_t;

endpackage

>>> design/fcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/fir_convolution_filter_top.sv
// FIR convolution filter: coefficient store, sample history and one shared MAC.
//
// Input channel (in_valid / in_stall): func selects the beat kind. A load beat
// writes coefficient into slot tap_index and gives no result. A sample beat
// shifts sample_in into the history and gives one result beat: the sum of
// coefficient[t] * x[n-t] over the active taps, rounded to Q1.15 and
// saturated, with clipped set when saturation acted.
// A sample beat runs one multiply-accumulate per tap through a single shared
// multiplier fed by two RAMs; a tap_count above 4096 counts as 4096, and with
// tap_count zero the sequencer goes straight to rounding. in_stall stays high
// until the result has been placed in the output register, so a new sample is
// not accepted before the last one is through.
// Output channel (out_valid / out_stall): the result sits in an output
// register, so the next beat is accepted while a result still waits. If the
// receiver stalls longer than the next computation, the sequencer holds in
// its final step until the register frees up.
// Configuration (cfg_valid / cfg_ready / cfg_data) writes tap_count; it is
// always ready and must only be written while the block is idle.
// Reset clears the history (through a fill count, not a sweep), sets the
// newest slot to zero and tap_count to 4096. Coefficients are not cleared and
// every active tap has to be loaded before samples are streamed.
module fir_convolution_filter_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  func,
  input  logic [fcf_pkg::IDX_BITS-1:0]          tap_index,
  input  logic signed [fcf_pkg::SAMPLE_BITS-1:0] coefficient,
  input  logic signed [fcf_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fcf_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                                  clipped,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fcf_pkg::CFG_BITS-1:0]          cfg_data
);

  fcf_pkg::state_t state, state_next;

  logic [fcf_pkg::CFG_BITS-1:0]  tap_count;
  logic [fcf_pkg::TAP_BITS-1:0]  newest_pos;
  logic [fcf_pkg::TAP_BITS-1:0]  pos_inc;
  logic [fcf_pkg::TAP_BITS-1:0]  rd_pos;
  logic [fcf_pkg::CNT_BITS-1:0]  fill;
  logic [fcf_pkg::CNT_BITS-1:0]  taps;
  logic [fcf_pkg::CNT_BITS-1:0]  taps_in;
  logic [fcf_pkg::CNT_BITS-1:0]  tap_cnt;
  logic                          s1_v;
  logic                          s1_live;
  logic                          s2_v;
  logic signed [fcf_pkg::PROD_BITS-1:0] prod;
  logic signed [fcf_pkg::ACC_BITS-1:0]  acc;
  logic signed [fcf_pkg::ACC_BITS-1:0]  rnd_sum;
  logic signed [fcf_pkg::ACC_BITS-1:0]  rnd_q;
  logic                          rnd_hi;
  logic                          rnd_lo;
  logic [fcf_pkg::SAMPLE_BITS-1:0] rnd_out;

  logic accept;
  logic accept_load;
  logic accept_sample;
  logic idx_ok;
  logic mac_issue;
  logic out_free;
  logic emit;

  logic coef_we;
  logic hist_we;
  logic [fcf_pkg::SAMPLE_BITS-1:0] coef_rd;
  logic [fcf_pkg::SAMPLE_BITS-1:0] hist_rd;

  assign cfg_ready = 1'b1;

  assign accept        = in_valid && !in_stall;
  assign accept_load   = accept && (fcf_pkg::func_t'(func) == fcf_pkg::FUNC_LOAD);
  assign accept_sample = accept && (fcf_pkg::func_t'(func) == fcf_pkg::FUNC_SAMPLE);
  assign idx_ok        = 32'(tap_index) < fcf_pkg::MAX_TAPS;
  assign out_free      = !out_valid || !out_stall;

  assign pos_inc = (32'(newest_pos) == fcf_pkg::MAX_TAPS - 1) ? '0
                 : newest_pos + fcf_pkg::TAP_BITS'(1);
  assign taps_in = (32'(tap_count) > fcf_pkg::MAX_TAPS) ? fcf_pkg::CNT_BITS'(fcf_pkg::MAX_TAPS)
                 : fcf_pkg::CNT_BITS'(tap_count);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      fcf_pkg::ST_IDLE: begin
        if (accept_sample) begin
          state_next = (taps_in == '0) ? fcf_pkg::ST_ROUND : fcf_pkg::ST_MAC;
        end
      end
      fcf_pkg::ST_MAC: begin
        if (tap_cnt == taps - fcf_pkg::CNT_BITS'(1)) begin
          state_next = fcf_pkg::ST_DRAIN;
        end
      end
      fcf_pkg::ST_DRAIN: begin
        if (!s1_v && !s2_v) begin
          state_next = fcf_pkg::ST_ROUND;
        end
      end
      fcf_pkg::ST_ROUND: begin
        if (out_free) begin
          state_next = fcf_pkg::ST_IDLE;
        end
      end
      default: state_next = fcf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    mac_issue = 1'b0;
    emit      = 1'b0;
    case (state)
      fcf_pkg::ST_IDLE:  in_stall  = 1'b0;
      fcf_pkg::ST_MAC:   mac_issue = 1'b1;
      fcf_pkg::ST_DRAIN: mac_issue = 1'b0;
      fcf_pkg::ST_ROUND: emit      = out_free;
      default:           in_stall  = 1'b1;
    endcase
  end

  assign coef_we = accept_load && idx_ok;
  assign hist_we = accept_sample;

  fcf_ram #(
    .WIDTH (fcf_pkg::SAMPLE_BITS),
    .DEPTH (fcf_pkg::MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (fcf_pkg::TAP_BITS'(tap_index)),
    .wdata (coefficient),
    .raddr (tap_cnt[fcf_pkg::TAP_BITS-1:0]),
    .rdata (coef_rd)
  );

  fcf_ram #(
    .WIDTH (fcf_pkg::SAMPLE_BITS),
    .DEPTH (fcf_pkg::MAX_TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (pos_inc),
    .wdata (sample_in),
    .raddr (rd_pos),
    .rdata (hist_rd)
  );

  // Rounding adds half an LSB and shifts with floor, then clamps to Q1.15.
  always_comb begin
    rnd_sum = acc + fcf_pkg::RND_HALF;
    rnd_q   = rnd_sum >>> fcf_pkg::FRAC_BITS;
    rnd_hi  = rnd_q > fcf_pkg::SAT_HI;
    rnd_lo  = rnd_q < fcf_pkg::SAT_LO;
    if (rnd_hi) begin
      rnd_out = fcf_pkg::SAMPLE_BITS'(fcf_pkg::SAT_HI);
    end else if (rnd_lo) begin
      rnd_out = fcf_pkg::SAMPLE_BITS'(fcf_pkg::SAT_LO);
    end else begin
      rnd_out = rnd_q[fcf_pkg::SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fcf_pkg::ST_IDLE;
      tap_count  <= fcf_pkg::TAP_COUNT_RESET;
      newest_pos <= '0;
      fill       <= '0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      s1_v  <= mac_issue;
      s2_v  <= s1_v;
      if (cfg_valid && cfg_ready) begin
        tap_count <= cfg_data;
      end
      if (accept_sample) begin
        newest_pos <= pos_inc;
        if (32'(fill) != fcf_pkg::MAX_TAPS) begin
          fill <= fill + fcf_pkg::CNT_BITS'(1);
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // MAC datapath: issue addresses, multiply the RAM words, then accumulate.
  always_ff @(posedge clk) begin
    if (accept_sample) begin
      taps    <= taps_in;
      tap_cnt <= '0;
      rd_pos  <= pos_inc;
      acc     <= '0;
    end else begin
      if (mac_issue) begin
        tap_cnt <= tap_cnt + fcf_pkg::CNT_BITS'(1);
        rd_pos  <= (rd_pos == '0) ? fcf_pkg::TAP_BITS'(fcf_pkg::MAX_TAPS - 1)
                 : rd_pos - fcf_pkg::TAP_BITS'(1);
      end
      if (s2_v) begin
        acc <= acc + fcf_pkg::ACC_BITS'(prod);
      end
    end
    // Slots older than the first pushed sample read as zero.
    s1_live <= tap_cnt < fill;
    if (s1_live) begin
      prod <= $signed(coef_rd) * $signed(hist_rd);
    end else begin
      prod <= '0;
    end
    if (emit) begin
      sample_out <= rnd_out;
      clipped    <= rnd_hi || rnd_lo;
    end
  end

endmodule

>>> design/fcf_checker.sv
// Port-level checks for the FIR convolution filter, bound to the top level.
module fcf_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  func,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [fcf_pkg::SAMPLE_BITS-1:0] sample_out,
  input logic                                  clipped
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(clipped))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present after reset");

  // A load beat with no result pending never produces one.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (fcf_pkg::func_t'(func) == fcf_pkg::FUNC_LOAD) && !out_valid
    |=> !out_valid)
    else $error("load beat produced a result");

  // A sample beat occupies the MAC, so the input must stall right after it.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (fcf_pkg::func_t'(func) == fcf_pkg::FUNC_SAMPLE)
    |=> in_stall)
    else $error("input accepted during a running convolution");

endmodule

bind fir_convolution_filter_top fcf_checker u_fcf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .func       (func),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .sample_out (sample_out),
  .clipped    (clipped)
);
